FILE: sv/cubemap_direction_to_texel_assert.svh
// Assertion macros for the cube-map texel addressing block.
// Included by every module of the block that carries concurrent checks.
`ifndef CUBEMAP_DIRECTION_TO_TEXEL_ASSERT_SVH
`define CUBEMAP_DIRECTION_TO_TEXEL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CDT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CDT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/cdt_pkg.sv
// Shared types and constants of the cube-map texel addressing block.
// No dependencies; used by every module of the block.
package cdt_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int SIZE_W         = 12;
   localparam int QUO_W          = SIZE_W;
   localparam int IDX_W          = 24;
   localparam int COLOUR_W       = 8;
   localparam int FACE_W         = 3;
   localparam int RSP_DATA_W     = ((FACE_W + 2 * SIZE_W + IDX_W + 3 * COLOUR_W + 7) / 8) * 8;

   localparam logic [SIZE_W-1:0] FACE_SIZE_RESET = 12'd1024;

   typedef enum logic [FACE_W-1:0] {
      FACE_XP = 3'd0,
      FACE_XN = 3'd1,
      FACE_YP = 3'd2,
      FACE_YN = 3'd3,
      FACE_ZP = 3'd4,
      FACE_ZN = 3'd5
   } face_type;

   // Fields that ride alongside the arithmetic through every stage.
   typedef struct packed {
      face_type            face;
      logic                zero;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } side_type;

endpackage

FILE: sv/cdt_front.sv
// Front end: face selection and projection, then the two numerator products.
// Depends on cdt_pkg and the assertion macro header.
`include "cubemap_direction_to_texel_assert.svh"
module cdt_front import cdt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int NW        = COORD_BITS + 1 + SIZE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SIZE_W-1:0]     face_size,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] dir_x,
   input  logic [COORD_BITS-1:0] dir_y,
   input  logic [COORD_BITS-1:0] dir_z,
   input  logic [COLOUR_W-1:0]   red,
   input  logic [COLOUR_W-1:0]   green,
   input  logic [COLOUR_W-1:0]   blue,
   output logic                  out_valid,
   input  logic                  out_ready,
   output side_type              out_side,
   output logic [COORD_BITS:0]   out_div,
   output logic [NW-1:0]         out_num_col,
   output logic [NW-1:0]         out_num_row
);

   logic [COORD_BITS-1:0] ax, ay, az, a_sel;
   logic [COORD_BITS:0]   xe, ye, ze, u_sel, v_sel;
   logic                  x_win, y_win;
   side_type              side_sel;

   logic                  va_ff, va_in, vb_ff, vb_in;
   logic                  rdy_a, rdy_b, load_a, load_b;
   side_type              side_a_ff, side_a_in, side_b_ff, side_b_in;
   logic [COORD_BITS-1:0] a_ff, a_in;
   logic [COORD_BITS:0]   su_ff, su_in, sv_ff, sv_in, div_ff, div_in;
   logic [NW-1:0]         ncol_ff, ncol_in, nrow_ff, nrow_in;

   assign ax = dir_x[COORD_BITS-1] ? (~dir_x + 1'b1) : dir_x;
   assign ay = dir_y[COORD_BITS-1] ? (~dir_y + 1'b1) : dir_y;
   assign az = dir_z[COORD_BITS-1] ? (~dir_z + 1'b1) : dir_z;
   assign xe = {dir_x[COORD_BITS-1], dir_x};
   assign ye = {dir_y[COORD_BITS-1], dir_y};
   assign ze = {dir_z[COORD_BITS-1], dir_z};

   // x must be strictly largest; y wins ties with x but not with z
   assign x_win = (ax > ay) && (ax > az);
   assign y_win = (ay >= ax) && (ay > az);

   always_comb begin
      side_sel       = '0;
      side_sel.zero  = (ax == '0) && (ay == '0) && (az == '0);
      side_sel.red   = red;
      side_sel.green = green;
      side_sel.blue  = blue;
      if (x_win) begin
         side_sel.face = dir_x[COORD_BITS-1] ? FACE_XN : FACE_XP;
         a_sel         = ax;
         u_sel         = dir_x[COORD_BITS-1] ? ye : -ye;
         v_sel         = ze;
      end else if (y_win) begin
         side_sel.face = dir_y[COORD_BITS-1] ? FACE_YN : FACE_YP;
         a_sel         = ay;
         u_sel         = dir_y[COORD_BITS-1] ? -xe : xe;
         v_sel         = ze;
      end else begin
         side_sel.face = dir_z[COORD_BITS-1] ? FACE_ZN : FACE_ZP;
         a_sel         = az;
         u_sel         = xe;
         v_sel         = dir_z[COORD_BITS-1] ? ye : -ye;
      end
   end

   // bubbles collapse: a stage takes a request when empty or when it drains
   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;
   assign load_a   = rdy_a && in_valid;
   assign load_b   = rdy_b && va_ff;

   always_comb begin
      va_in     = rdy_a ? in_valid : va_ff;
      vb_in     = rdy_b ? va_ff : vb_ff;
      side_a_in = side_sel;
      a_in      = a_sel;
      // n + a lies in [0, 2a], so the wrap of the narrow add is harmless
      su_in     = u_sel + {1'b0, a_sel};
      sv_in     = v_sel + {1'b0, a_sel};
      side_b_in = side_a_ff;
      div_in    = {a_ff, 1'b0};
      ncol_in   = {{SIZE_W{1'b0}}, su_ff} * {{(COORD_BITS + 1){1'b0}}, face_size};
      nrow_in   = {{SIZE_W{1'b0}}, sv_ff} * {{(COORD_BITS + 1){1'b0}}, face_size};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         side_a_ff <= side_a_in;
         a_ff      <= a_in;
         su_ff     <= su_in;
         sv_ff     <= sv_in;
      end
      if (load_b) begin
         side_b_ff <= side_b_in;
         div_ff    <= div_in;
         ncol_ff   <= ncol_in;
         nrow_ff   <= nrow_in;
      end
   end

   assign out_valid   = vb_ff;
   assign out_side    = side_b_ff;
   assign out_div     = div_ff;
   assign out_num_col = ncol_ff;
   assign out_num_row = nrow_ff;

   `CDT_ASSERT_IMPLIES(a_front_sum_bound, clock, reset,
      va_ff, (su_ff <= {a_ff, 1'b0}) && (sv_ff <= {a_ff, 1'b0}),
      "projected coordinate outside [0, 2a]")
   `CDT_ASSERT_NEXT(a_front_take, clock, reset,
      in_valid && in_ready, va_ff,
      "accepted request lost at the first stage")

endmodule

FILE: sv/cdt_div_cell.sv
// One restoring-division cell: settles quotient bit SHIFT for column and row.
// Depends on cdt_pkg and the assertion macro header.
`include "cubemap_direction_to_texel_assert.svh"
module cdt_div_cell import cdt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SHIFT      = 0,
   localparam int NW        = COORD_BITS + 1 + SIZE_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  side_type            in_side,
   input  logic [COORD_BITS:0] in_div,
   input  logic [NW-1:0]       in_rem_col,
   input  logic [NW-1:0]       in_rem_row,
   input  logic [QUO_W-1:0]    in_quo_col,
   input  logic [QUO_W-1:0]    in_quo_row,
   output logic                out_valid,
   input  logic                out_ready,
   output side_type            out_side,
   output logic [COORD_BITS:0] out_div,
   output logic [NW-1:0]       out_rem_col,
   output logic [NW-1:0]       out_rem_row,
   output logic [QUO_W-1:0]    out_quo_col,
   output logic [QUO_W-1:0]    out_quo_row
);

   logic [NW-1:0]         dsh, dsh_held;
   logic                  ge_col, ge_row, load;
   logic                  valid_ff, valid_in;
   side_type              side_ff;
   logic [COORD_BITS:0]   div_ff;
   logic [NW-1:0]         rem_col_ff, rem_col_in, rem_row_ff, rem_row_in;
   logic [QUO_W-1:0]      quo_col_ff, quo_col_in, quo_row_ff, quo_row_in;

   assign dsh      = NW'(in_div) << SHIFT;
   assign ge_col   = in_rem_col >= dsh;
   assign ge_row   = in_rem_row >= dsh;
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in          = in_ready ? in_valid : valid_ff;
      rem_col_in        = ge_col ? (in_rem_col - dsh) : in_rem_col;
      rem_row_in        = ge_row ? (in_rem_row - dsh) : in_rem_row;
      quo_col_in        = in_quo_col;
      quo_row_in        = in_quo_row;
      quo_col_in[SHIFT] = ge_col;
      quo_row_in[SHIFT] = ge_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff    <= in_side;
         div_ff     <= in_div;
         rem_col_ff <= rem_col_in;
         rem_row_ff <= rem_row_in;
         quo_col_ff <= quo_col_in;
         quo_row_ff <= quo_row_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_div     = div_ff;
   assign out_rem_col = rem_col_ff;
   assign out_rem_row = rem_row_ff;
   assign out_quo_col = quo_col_ff;
   assign out_quo_row = quo_row_ff;

   assign dsh_held = NW'(div_ff) << SHIFT;

   `CDT_ASSERT_IMPLIES(a_cell_rem_bound, clock, reset,
      valid_ff && (div_ff != '0),
      (rem_col_ff < dsh_held) && (rem_row_ff < dsh_held),
      "partial remainder not reduced below shifted divisor")

endmodule

FILE: sv/cdt_back.sv
// Back end: clamp of the quotients, linear index and the output register.
// Depends on cdt_pkg.
module cdt_back import cdt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SIZE_W-1:0]   face_size,
   input  logic                in_valid,
   output logic                in_ready,
   input  side_type            in_side,
   input  logic [QUO_W-1:0]    in_quo_col,
   input  logic [QUO_W-1:0]    in_quo_row,
   output logic                out_valid,
   input  logic                out_ready,
   output side_type            out_side,
   output logic [SIZE_W-1:0]   out_column,
   output logic [SIZE_W-1:0]   out_row,
   output logic [IDX_W-1:0]    out_index
);

   logic                rdy_c, rdy_d, load_c, load_d, blank;
   logic                vc_ff, vc_in, vd_ff, vd_in;
   side_type            side_c_ff, side_d_ff;
   logic [SIZE_W-1:0]   col_c_ff, col_c_in, row_c_ff, row_c_in;
   logic [SIZE_W-1:0]   col_d_ff, row_d_ff;
   logic [IDX_W-1:0]    idx_d_ff, idx_d_in;

   assign rdy_d    = !vd_ff || out_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign in_ready = rdy_c;
   assign load_c   = rdy_c && in_valid;
   assign load_d   = rdy_d && vc_ff;

   // zero vector and zero face size give the origin
   assign blank = in_side.zero || (face_size == '0);

   always_comb begin
      vc_in = rdy_c ? in_valid : vc_ff;
      vd_in = rdy_d ? vc_ff : vd_ff;
      // minor equal to major lands one past the edge: pull it back
      if (blank) begin
         col_c_in = '0;
      end else if (in_quo_col >= face_size) begin
         col_c_in = face_size - 1'b1;
      end else begin
         col_c_in = in_quo_col;
      end
      if (blank) begin
         row_c_in = '0;
      end else if (in_quo_row >= face_size) begin
         row_c_in = face_size - 1'b1;
      end else begin
         row_c_in = in_quo_row;
      end
      idx_d_in = {{(IDX_W - SIZE_W){1'b0}}, row_c_ff} * {{(IDX_W - SIZE_W){1'b0}}, face_size}
               + {{(IDX_W - SIZE_W){1'b0}}, col_c_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         side_c_ff <= in_side;
         col_c_ff  <= col_c_in;
         row_c_ff  <= row_c_in;
      end
      if (load_d) begin
         side_d_ff <= side_c_ff;
         col_d_ff  <= col_c_ff;
         row_d_ff  <= row_c_ff;
         idx_d_ff  <= idx_d_in;
      end
   end

   assign out_valid  = vd_ff;
   assign out_side   = side_d_ff;
   assign out_column = col_d_ff;
   assign out_row    = row_d_ff;
   assign out_index  = idx_d_ff;

endmodule

FILE: sv/cubemap_direction_to_texel.sv
// Top level of the cube-map texel addressing block: ports, face size register, cell row.
// Depends on cdt_pkg, cdt_front, cdt_div_cell, cdt_back and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_tvalid/tready    | req_tdata: direction, colour
//   rsp     | out       | rsp_tvalid/tready    | rsp_tdata: face, texel, colour; tuser
//   csr     | in        | csr_valid/ready      | csr_data: face size
//
// One request per cycle while results are taken; each takes 2 front stages, one division cell
// per quotient bit (12) and 2 back stages.
// Reset is synchronous; it empties every stage and sets the face size to 1024.
// Each stage holds its request while the next is full; a stalled result leaves
// earlier empty stages free to take new requests.
`include "cubemap_direction_to_texel_assert.svh"
module cubemap_direction_to_texel import cdt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int REQ_W     = ((3 * COORD_BITS + 3 * COLOUR_W + 7) / 8) * 8,
   localparam int NW        = COORD_BITS + 1 + SIZE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dir_x, dir_y, dir_z, red, green, blue, zero padding
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // face, column, row, texel_index, out_red, out_green, out_blue, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // zero_direction
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_data
);

   logic [SIZE_W-1:0]   face_size_ff, face_size_in;

   logic [QUO_W:0]      c_valid, c_ready;
   side_type            c_side    [QUO_W+1];
   logic [COORD_BITS:0] c_div     [QUO_W+1];
   logic [NW-1:0]       c_rem_col [QUO_W+1];
   logic [NW-1:0]       c_rem_row [QUO_W+1];
   logic [QUO_W-1:0]    c_quo_col [QUO_W+1];
   logic [QUO_W-1:0]    c_quo_row [QUO_W+1];

   side_type            rsp_side;
   logic [SIZE_W-1:0]   rsp_column, rsp_row;
   logic [IDX_W-1:0]    rsp_index;

   assign csr_ready    = 1'b1;
   assign face_size_in = (csr_valid && csr_ready) ? csr_data : face_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_SIZE_RESET;
      end else begin
         face_size_ff <= face_size_in;
      end
   end

   cdt_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .face_size   (face_size_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .dir_x       (req_tdata[0 +: COORD_BITS]),
      .dir_y       (req_tdata[COORD_BITS +: COORD_BITS]),
      .dir_z       (req_tdata[2 * COORD_BITS +: COORD_BITS]),
      .red         (req_tdata[3 * COORD_BITS +: COLOUR_W]),
      .green       (req_tdata[3 * COORD_BITS + COLOUR_W +: COLOUR_W]),
      .blue        (req_tdata[3 * COORD_BITS + 2 * COLOUR_W +: COLOUR_W]),
      .out_valid   (c_valid[0]),
      .out_ready   (c_ready[0]),
      .out_side    (c_side[0]),
      .out_div     (c_div[0]),
      .out_num_col (c_rem_col[0]),
      .out_num_row (c_rem_row[0])
   );

   assign c_quo_col[0] = '0;
   assign c_quo_row[0] = '0;

   // most significant quotient bit first
   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      cdt_div_cell #(.COORD_BITS(COORD_BITS), .SHIFT(QUO_W - 1 - i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (c_valid[i]),
         .in_ready    (c_ready[i]),
         .in_side     (c_side[i]),
         .in_div      (c_div[i]),
         .in_rem_col  (c_rem_col[i]),
         .in_rem_row  (c_rem_row[i]),
         .in_quo_col  (c_quo_col[i]),
         .in_quo_row  (c_quo_row[i]),
         .out_valid   (c_valid[i+1]),
         .out_ready   (c_ready[i+1]),
         .out_side    (c_side[i+1]),
         .out_div     (c_div[i+1]),
         .out_rem_col (c_rem_col[i+1]),
         .out_rem_row (c_rem_row[i+1]),
         .out_quo_col (c_quo_col[i+1]),
         .out_quo_row (c_quo_row[i+1])
      );
   end

   cdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .face_size  (face_size_ff),
      .in_valid   (c_valid[QUO_W]),
      .in_ready   (c_ready[QUO_W]),
      .in_side    (c_side[QUO_W]),
      .in_quo_col (c_quo_col[QUO_W]),
      .in_quo_row (c_quo_row[QUO_W]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_side   (rsp_side),
      .out_column (rsp_column),
      .out_row    (rsp_row),
      .out_index  (rsp_index)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_side.blue, rsp_side.green, rsp_side.red,
                                   rsp_index, rsp_row, rsp_column, rsp_side.face});
   assign rsp_tuser = rsp_side.zero;

   `CDT_ASSERT_IMPLIES(a_zero_at_origin, clock, reset,
      rsp_tvalid && rsp_side.zero,
      (rsp_column == '0) && (rsp_row == '0) && (rsp_index == '0),
      "zero direction with a non-zero texel address")
   `CDT_ASSERT_IMPLIES(a_texel_on_face, clock, reset,
      rsp_tvalid && (face_size_ff != '0),
      (rsp_column < face_size_ff) && (rsp_row < face_size_ff),
      "texel position beyond the face edge")

endmodule
